[rtl/mps_pkg.sv]
// mps_pkg: shared types and constants for the mosaic pixelate stream block
// no dependencies; imported by mosaic_pixelate_stream
`default_nettype none

package mps_pkg;

	// configuration register map
	typedef enum logic [0:0] {
		REG_BLOCK_SIZE  = 1'b0,
		REG_FRAME_WIDTH = 1'b1
	} cfg_reg_t;

	localparam int unsigned BS_W       = 6;   // block_size register width
	localparam int unsigned FW_W       = 13;  // frame_width register width
	localparam int unsigned CFG_W      = 13;  // widest register
	localparam int unsigned CIB_W      = 5;   // column/row in block counters
	localparam int unsigned BS_MIN     = 4;
	localparam int unsigned BS_MAX     = 32;
	localparam int unsigned BS_RESET   = 8;
	localparam int unsigned FW_RESET   = 640;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned COLOR_W    = 3 * CHAN_W;
	localparam int unsigned PIX_W      = 4 * CHAN_W;

	typedef logic [COLOR_W-1:0] color_t;

	// clamp block size register into the supported range
	function automatic logic [BS_W-1:0] clamp_block(input logic [BS_W-1:0] b);
		logic [BS_W-1:0] r;
		r = b;
		if (b < BS_W'(BS_MIN))
			r = BS_W'(BS_MIN);
		else if (b > BS_W'(BS_MAX))
			r = BS_W'(BS_MAX);
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/mosaic_pixelate_stream.sv]
// mosaic_pixelate_stream: streaming mosaic (pixelate) filter, top level
// depends on mps_pkg; holds the block color line store as an internal memory
//
// usage
//   input stream: s_tdata carries one pixel (blue, green, red, alpha), s_tuser
//   marks the first pixel of a frame. output stream: m_tdata carries the
//   pixel with blue/green/red replaced by its block's top-left color and alpha
//   unchanged. one result per request, in order.
//   configuration: cfg_we/cfg_index/cfg_data write block_size (index 0) or
//   frame_width (index 1); write only while the stream is idle.
//   throughput: one pixel per clock unless m_tready stalls the output, set by the
//   single-port read of the line store which is issued at the same edge that takes the request.
//   path: a request passes the stage 1 register (holding the line store read
//   data), then the output register.
//   stall: the output register and the stage before it keep the pipe full;
//   s_tready drops only when both hold data and m_tready is low.
//   reset: counters go to zero so the first pixel opens a frame even without
//   a start mark; registers return to block_size 8 and frame_width 640. the
//   line store is not cleared, its entries are written on each band's first
//   row before they are read.
`default_nettype none

module mosaic_pixelate_stream import mps_pkg::*; #(
	parameter int unsigned MAX_WIDTH         = 4096,
	parameter int unsigned MAX_BLOCK_COLUMNS = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration write port
	input  wire logic                cfg_we,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data,
	// input pixel stream
	input  wire logic                s_tvalid,
	output      logic                s_tready,
	input  wire logic [PIX_W-1:0]    s_tdata,  // blue_in, green_in, red_in, alpha_in
	input  wire logic                s_tuser,  // start_of_frame
	// output pixel stream
	output      logic                m_tvalid,
	input  wire logic                m_tready,
	output      logic [PIX_W-1:0]    m_tdata   // blue_out, green_out, red_out, alpha_out
);

	// column counter wide enough to hold MAX_WIDTH itself for compares
	localparam int unsigned CC_W = $clog2(MAX_WIDTH) + 1;
	localparam int unsigned AW   = $clog2(MAX_BLOCK_COLUMNS);

	// configuration registers
	logic [BS_W-1:0] block_size_q;
	logic [FW_W-1:0] frame_width_q;

	// raster position state
	logic [CC_W-1:0]  column_count_q;
	logic [CIB_W-1:0] row_in_block_q;
	logic [CIB_W-1:0] column_in_block_q;
	logic [CC_W-1:0]  block_column_q;

	// stage 1: registered pixel plus line store read data
	logic            valid_s1;
	logic            take_new_s1;   // first row of band, block's first column
	logic            take_mem_s1;   // later row of band, block's first column
	color_t          color_s1;
	logic [CHAN_W-1:0] alpha_s1;
	color_t          rdata_s1;

	// output register and last block color
	logic            out_valid_q;
	logic [PIX_W-1:0] out_data_q;
	color_t          held_q;

	color_t          line_mem [MAX_BLOCK_COLUMNS];

	logic            accept;
	logic            advance;
	logic [BS_W-1:0] bs_eff;
	logic [CC_W-1:0] fw_eff;
	logic [CC_W-1:0] cc_cur;
	logic [CIB_W-1:0] rib_cur;
	logic [CIB_W-1:0] cib_cur;
	logic [CC_W-1:0] bc_cur;
	logic [AW-1:0]   line_idx;
	logic            first_col;
	logic            first_row;
	logic            block_end;
	logic            row_end;
	color_t          color_in;
	color_t          color_sel;

	// pipe moves when the output slot is free or being emptied
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign color_in = s_tdata[COLOR_W-1:0];

	// effective register values, saturated into range
	always_comb begin
		bs_eff = clamp_block(block_size_q);
		if (frame_width_q == '0)
			fw_eff = CC_W'(1);
		else if ({1'b0, frame_width_q} > (FW_W+1)'(MAX_WIDTH))
			fw_eff = CC_W'(MAX_WIDTH);
		else
			fw_eff = CC_W'(frame_width_q);
	end

	// position of the pixel being taken; a start mark restarts the raster
	always_comb begin
		if (s_tuser) begin
			cc_cur  = '0;
			rib_cur = '0;
			cib_cur = '0;
			bc_cur  = '0;
		end else begin
			cc_cur  = column_count_q;
			rib_cur = row_in_block_q;
			cib_cur = column_in_block_q;
			bc_cur  = block_column_q;
		end
		// block columns past the store share its last entry
		if (bc_cur > CC_W'(MAX_BLOCK_COLUMNS - 1))
			line_idx = AW'(MAX_BLOCK_COLUMNS - 1);
		else
			line_idx = bc_cur[AW-1:0];
		first_col = (cib_cur == '0);
		first_row = (rib_cur == '0);
		block_end = ({1'b0, cib_cur} + 1'b1) >= bs_eff;
		row_end   = (cc_cur + 1'b1) >= fw_eff;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= BS_W'(BS_RESET);
			frame_width_q <= FW_W'(FW_RESET);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BLOCK_SIZE:  block_size_q  <= cfg_data[BS_W-1:0];
				REG_FRAME_WIDTH: frame_width_q <= cfg_data[FW_W-1:0];
				default:         ;
			endcase
		end
	end

	// raster counters advance once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q    <= '0;
			row_in_block_q    <= '0;
			column_in_block_q <= '0;
			block_column_q    <= '0;
		end else if (accept) begin
			if (row_end) begin
				column_count_q    <= '0;
				column_in_block_q <= '0;
				block_column_q    <= '0;
				if (({1'b0, rib_cur} + 1'b1) >= bs_eff)
					row_in_block_q <= '0;
				else
					row_in_block_q <= rib_cur + 1'b1;
			end else begin
				column_count_q <= cc_cur + 1'b1;
				row_in_block_q <= rib_cur;
				if (block_end) begin
					column_in_block_q <= '0;
					block_column_q    <= bc_cur + 1'b1;
				end else begin
					column_in_block_q <= cib_cur + 1'b1;
					block_column_q    <= bc_cur;
				end
			end
		end
	end

	// line store: top-left colors written on a band's first row, read after
	always_ff @(posedge clk) begin
		if (accept) begin
			if (first_col && first_row)
				line_mem[line_idx] <= color_in;
			rdata_s1 <= line_mem[line_idx];
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			take_new_s1 <= first_col && first_row;
			take_mem_s1 <= first_col && !first_row;
			color_s1    <= color_in;
			alpha_s1    <= s_tdata[PIX_W-1:COLOR_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	// block color for the pixel in stage 1
	always_comb begin
		priority if (take_new_s1)
			color_sel = color_s1;
		else if (take_mem_s1)
			color_sel = rdata_s1;
		else
			color_sel = held_q;
	end

	// output register and held color
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1)
				held_q <= color_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			out_data_q <= {alpha_s1, color_sel};
	end

	// a taken request always lands in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
	else $error("request lost before stage 1");

	// a full pipe with a stalled receiver must refuse new requests
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
	else $error("request taken while pipe is full");

	// a stalled output keeps its pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
	else $error("output changed under stall");

	// block column never runs past MAX_WIDTH
	assert property (@(posedge clk) disable iff (!arst_n)
		block_column_q <= CC_W'(MAX_WIDTH))
	else $error("block column out of range");

endmodule

`default_nettype wire
